FILE: rtl/core/ycrc_pkg.sv
// ycrc_pkg: shared types and constants for the YUV colour range classifier.
// No dependencies; imported by every module of the core.
package ycrc_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int MASK_W    = 8;
  localparam int REG_COUNT = 8;
  localparam int CFG_IDX_W = $clog2(REG_COUNT);
  localparam int RANGE_W   = 6 * SAMPLE_W;
  localparam int PAIR_W    = SAMPLE_W + 1;
  localparam int SUM_W     = SAMPLE_W + 2;

  // Byte order of one colour register, y_lo in the lowest byte
  typedef struct packed {
    logic [SAMPLE_W-1:0] v_hi;
    logic [SAMPLE_W-1:0] v_lo;
    logic [SAMPLE_W-1:0] u_hi;
    logic [SAMPLE_W-1:0] u_lo;
    logic [SAMPLE_W-1:0] y_hi;
    logic [SAMPLE_W-1:0] y_lo;
  } range_t;

  // Partial luma sums after the first stage
  typedef struct packed {
    logic [PAIR_W-1:0]   sum_top;
    logic [PAIR_W-1:0]   sum_bot;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] v;
  } luma_part_t;

  // One averaged site
  typedef struct packed {
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] v;
  } site_t;

  // Half-open range test; lo > hi wraps past the top, lo == hi is empty
  function automatic logic in_range(input logic [SAMPLE_W-1:0] x,
                                    input logic [SAMPLE_W-1:0] lo,
                                    input logic [SAMPLE_W-1:0] hi);
    logic ge_lo;
    logic lt_hi;
    ge_lo = (x >= lo);
    lt_hi = (x < hi);
    if (lo < hi) begin
      in_range = ge_lo && lt_hi;
    end else if (lo > hi) begin
      in_range = ge_lo || lt_hi;
    end else begin
      in_range = 1'b0;
    end
  endfunction

endpackage

FILE: rtl/core/ycrc_if.sv
// ycrc_in_if / ycrc_out_if: valid/ready channels of the classifier core.
// No dependencies.
interface ycrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v,
    output ready
  );
endinterface

interface ycrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_mask;

  modport source (output valid, color_mask, input ready);
  modport sink (input valid, color_mask, output ready);
endinterface

FILE: rtl/core/ycrc_cfg_regs.sv
// ycrc_cfg_regs: colour range register file, written through the cfg port.
// Depends on ycrc_pkg.
module ycrc_cfg_regs
  import ycrc_pkg::*;
#(
  parameter int NUM_COLORS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [RANGE_W-1:0]           cfg_wdata,
  output range_t [NUM_COLORS-1:0]      ranges
);

  range_t [NUM_COLORS-1:0] range_r;

  // Writes to colours beyond NUM_COLORS have no effect on the mask
  for (genvar k = 0; k < NUM_COLORS; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        range_r[k] <= '0;
      end else if (cfg_we && (cfg_index == CFG_IDX_W'(k))) begin
        range_r[k] <= range_t'(cfg_wdata);
      end
    end
  end

  assign ranges = range_r;

endmodule

FILE: rtl/core/ycrc_luma_avg.sv
// ycrc_luma_avg: two-stage 2x2 luma averaging with chroma carried alongside.
// Depends on ycrc_pkg and ycrc_in_if.
module ycrc_luma_avg
  import ycrc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  ycrc_in_if.sink in_chan,
  output logic   site_valid,
  input  logic   site_ready,
  output site_t  site
);

  logic       s1_valid_r, s1_valid_nxt;
  luma_part_t s1_data_r;
  logic       s1_ready;
  logic       s2_valid_r, s2_valid_nxt;
  site_t      s2_data_r;
  logic       s2_ready;
  logic [SUM_W-1:0] sum_full;

  // Each stage takes a new request when empty or when it drains this cycle
  assign s2_ready      = !s2_valid_r || site_ready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_chan.ready = s1_ready;

  assign s1_valid_nxt = s1_ready ? in_chan.valid : s1_valid_r;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  assign sum_full = SUM_W'(s1_data_r.sum_top) + SUM_W'(s1_data_r.sum_bot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_data_r.sum_top <= PAIR_W'(in_chan.luma_top_left) + PAIR_W'(in_chan.luma_top_right);
      s1_data_r.sum_bot <= PAIR_W'(in_chan.luma_bottom_left)
                         + PAIR_W'(in_chan.luma_bottom_right);
      s1_data_r.u       <= in_chan.chroma_u;
      s1_data_r.v       <= in_chan.chroma_v;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r.y <= sum_full[SUM_W-1:2];  // truncating divide by four
      s2_data_r.u <= s1_data_r.u;
      s2_data_r.v <= s1_data_r.v;
    end
  end

  assign site_valid = s2_valid_r;
  assign site       = s2_data_r;

endmodule

FILE: rtl/core/ycrc_range_match.sv
// ycrc_range_match: per-colour range compares, then mask reduction and output register.
// Depends on ycrc_pkg and ycrc_out_if.
module ycrc_range_match
  import ycrc_pkg::*;
#(
  parameter int NUM_COLORS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    site_valid,
  output logic                    site_ready,
  input  site_t                   site,
  input  range_t [NUM_COLORS-1:0] ranges,
  ycrc_out_if.source              out_chan
);

  logic                       s3_valid_r, s3_valid_nxt;
  logic [NUM_COLORS-1:0][2:0] s3_hit_r, s3_hit_nxt;
  logic                       s3_ready;
  logic                       s4_valid_r, s4_valid_nxt;
  logic [MASK_W-1:0]          s4_mask_r, s4_mask_nxt;
  logic                       s4_ready;

  assign s4_ready   = !s4_valid_r || out_chan.ready;
  assign s3_ready   = !s3_valid_r || s4_ready;
  assign site_ready = s3_ready;

  assign s3_valid_nxt = s3_ready ? site_valid : s3_valid_r;
  assign s4_valid_nxt = s4_ready ? s3_valid_r : s4_valid_r;

  always_comb begin
    for (int k = 0; k < NUM_COLORS; k++) begin
      s3_hit_nxt[k][0] = in_range(site.y, ranges[k].y_lo, ranges[k].y_hi);
      s3_hit_nxt[k][1] = in_range(site.u, ranges[k].u_lo, ranges[k].u_hi);
      s3_hit_nxt[k][2] = in_range(site.v, ranges[k].v_lo, ranges[k].v_hi);
    end
  end

  // Bits at NUM_COLORS and above stay clear
  always_comb begin
    s4_mask_nxt = '0;
    for (int k = 0; k < NUM_COLORS; k++) begin
      s4_mask_nxt[k] = &s3_hit_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && site_valid) begin
      s3_hit_r <= s3_hit_nxt;
    end
    if (s4_ready && s3_valid_r) begin
      s4_mask_r <= s4_mask_nxt;
    end
  end

  assign out_chan.valid      = s4_valid_r;
  assign out_chan.color_mask = s4_mask_r;

endmodule

FILE: rtl/core/yuv_color_range_classifier_core.sv
// yuv_color_range_classifier_core: top level of the 4:2:0 colour range classifier.
// Stages from request accept to result valid: pair sum, average, range compares,
// mask AND/output register. Throughput: one request per cycle while the sink is
// ready; each stage has its own valid bit and drains independently under stall.
// Reset (rst_n, synchronous, active low) empties the pipe and sets every colour
// range to empty, so the mask reads zero until ranges are written.
module yuv_color_range_classifier_core
  import ycrc_pkg::*;
#(
  parameter int NUM_COLORS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ycrc_in_if.sink              in_chan,
  ycrc_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANGE_W-1:0]   cfg_wdata
);

  // Colour ranges, kept static by the user while requests are in flight; unchecked
  range_t [NUM_COLORS-1:0] ranges;

  // Averaged site between the two halves of the pipe
  logic  site_valid;
  logic  site_ready;
  site_t site;

  ycrc_cfg_regs #(
    .NUM_COLORS (NUM_COLORS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ranges    (ranges)
  );

  // Stages 1-2: luma pair sums, then sum of four shifted right by two
  ycrc_luma_avg u_luma_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .site_valid (site_valid),
    .site_ready (site_ready),
    .site       (site)
  );

  // Stages 3-4: 3 x NUM_COLORS half-open compares, then AND per colour
  ycrc_range_match #(
    .NUM_COLORS (NUM_COLORS)
  ) u_range_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .site_valid (site_valid),
    .site_ready (site_ready),
    .site       (site),
    .ranges     (ranges),
    .out_chan   (out_chan)
  );

  // Mask bits of unused colours never set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ((out_chan.color_mask >> NUM_COLORS) == '0))
    else $error("mask bit set above NUM_COLORS");

  // A free-running sink means the whole pipe flows, so input is ready
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while output sink ready");

  // With the sink ready throughout, an accepted request reaches the output
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) ##1 out_chan.ready ##1 out_chan.ready
      ##1 out_chan.ready |=> out_chan.valid)
    else $error("request lost in pipe");

endmodule

FILE: dv/ycrc_mask_checker.sv
// ycrc_mask_checker: watches the request, result and register ports of the
// colour range classifier, predicts each colour mask and compares in order.
// Depends on ycrc_pkg and the ycrc_in_if / ycrc_out_if interfaces.
module ycrc_mask_checker
  import ycrc_pkg::*;
#(
  parameter int NUM_COLORS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ycrc_in_if                   in_mon,
  ycrc_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANGE_W-1:0]   cfg_wdata,
  output int                   mismatch_count,
  output int                   masks_outstanding
);

  range_t     color_ranges [REG_COUNT];
  logic [7:0] expected_masks [$];

  // Offset from lo taken mod 256 must fall below the span; this covers the
  // wrapping case too. lo == hi is an empty range.
  function automatic bit axis_hit(input logic [7:0] x, input logic [7:0] lo,
                                  input logic [7:0] hi);
    logic [7:0] offs;
    logic [7:0] span;
    offs = x - lo;
    span = hi - lo;
    axis_hit = (lo != hi) && (offs < span);
  endfunction

  function automatic logic [7:0] classify_site(input logic [7:0] tl, tr, bl, br,
                                               input logic [7:0] u, v);
    logic [9:0] luma_sum;
    logic [7:0] y;
    logic [7:0] mask;
    range_t     r;
    int         k;
    luma_sum = {2'b00, tl} + {2'b00, tr} + {2'b00, bl} + {2'b00, br};
    y        = luma_sum[9:2];
    mask     = '0;
    for (k = 0; k < REG_COUNT; k++) begin
      r = color_ranges[k];
      if (k < NUM_COLORS && axis_hit(y, r.y_lo, r.y_hi) &&
          axis_hit(u, r.u_lo, r.u_hi) && axis_hit(v, r.v_lo, r.v_hi)) begin
        mask[k] = 1'b1;
      end
    end
    classify_site = mask;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: mask error: %s: expected %02h, got %02h", $time, what, want, got);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count    = 0;
    masks_outstanding = 0;
  end

  always @(posedge clk) begin
    int k;
    logic [7:0] want;
    if (!rst_n) begin
      expected_masks.delete();
      for (k = 0; k < REG_COUNT; k++) begin
        color_ranges[k] = '0;
      end
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_masks.push_back(classify_site(in_mon.luma_top_left,
                                               in_mon.luma_top_right,
                                               in_mon.luma_bottom_left,
                                               in_mon.luma_bottom_right,
                                               in_mon.chroma_u, in_mon.chroma_v));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_masks.size() == 0) begin
          report_mismatch("result with no request outstanding", 'x, out_mon.color_mask);
        end else begin
          want = expected_masks.pop_front();
          if (out_mon.color_mask !== want) begin
            report_mismatch("color_mask", want, out_mon.color_mask);
          end
        end
      end
      // register writes take effect for requests after this edge
      if (cfg_we) begin
        color_ranges[cfg_index] = cfg_wdata;
      end
    end
    masks_outstanding = expected_masks.size();
  end

endmodule

FILE: dv/tb_yuv_color_range_classifier_core.sv
// tb_yuv_color_range_classifier_core: stimulus and verdict for the classifier core.
// Drives requests, result back-pressure and range registers; the checking is done
// by ycrc_mask_checker. Depends on ycrc_pkg, ycrc_if, the checker and the core.
module tb_yuv_color_range_classifier_core
  import ycrc_pkg::*;
();

  localparam int COLORS = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RANGE_W-1:0]   cfg_wdata;

  int     mismatch_count;
  int     masks_outstanding;

  // Ranges as last programmed; used to aim requests at the range edges
  range_t range_plan [REG_COUNT];

  // Idling controls: 0 switches a side's random idling off, otherwise a gap
  // or stall starts with odds 1 in N per request/cycle.
  int     sender_gap_odds;
  int     sink_stall_odds;
  // Set by the stimulus to make the receiver hold off for a long stretch
  bit     sink_hold_req;

  ycrc_in_if  in_chan ();
  ycrc_out_if out_chan ();

  yuv_color_range_classifier_core #(
    .NUM_COLORS (COLORS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ycrc_mask_checker #(
    .NUM_COLORS (COLORS)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_chan),
    .out_mon           (out_chan),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .masks_outstanding (masks_outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Range helpers
  // ---------------------------------------------------------------------------

  // Register layout: y_lo in the lowest byte, then y_hi, u_lo, u_hi, v_lo, v_hi
  function automatic range_t pack_range(input logic [7:0] ylo, yhi, ulo, uhi,
                                        input logic [7:0] vlo, vhi);
    pack_range = {vhi, vlo, uhi, ulo, yhi, ylo};
  endfunction

  // One axis as {hi, lo}: ordinary, wrapping, empty or one of the edge ranges
  function automatic logic [15:0] random_axis();
    logic [7:0] a;
    logic [7:0] b;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       random_axis = {a, a};            // empty
      1:       random_axis = {8'd0, 8'd1};      // wraps: everything but 0
      2:       random_axis = {8'd255, 8'd0};    // everything but 255
      3:       random_axis = {8'd0, 8'd255};    // 255 only
      4, 5, 6: random_axis = (a < b) ? {b, a} : {a, b};
      default: random_axis = (a < b) ? {a, b} : {b, a};
    endcase
  endfunction

  function automatic range_t random_range();
    random_range = {random_axis(), random_axis(), random_axis()};
  endfunction

  // A sample on, just off or just inside a range edge, or anywhere
  function automatic logic [7:0] near_edge(input logic [7:0] lo, hi);
    logic [7:0] span;
    logic [7:0] offs;
    span = hi - lo;
    offs = (span == 8'd0) ? 8'd0 : 8'($urandom_range(0, span - 1));
    case ($urandom_range(0, 5))
      0:       near_edge = lo;
      1:       near_edge = lo - 8'd1;
      2:       near_edge = hi;
      3:       near_edge = hi - 8'd1;
      4:       near_edge = lo + offs;
      default: near_edge = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Four luma samples whose truncated average is y
  task automatic spread_luma(input logic [7:0] y,
                             output logic [7:0] l0, l1, l2, l3);
    int total;
    int lo_b;
    int hi_b;
    int part [4];
    int i;
    total = 4 * y + ((y == 8'd255) ? 0 : $urandom_range(0, 3));
    for (i = 0; i < 3; i++) begin
      lo_b    = total - 255 * (3 - i);
      lo_b    = (lo_b < 0) ? 0 : lo_b;
      hi_b    = (total > 255) ? 255 : total;
      part[i] = $urandom_range(lo_b, hi_b);
      total   = total - part[i];
    end
    part[3] = total;
    l0 = part[0][7:0];
    l1 = part[1][7:0];
    l2 = part[2][7:0];
    l3 = part[3][7:0];
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Everything changes at the falling edge; ready is looked at
  // just after the rising edge, before the core's own registers update.
  // ---------------------------------------------------------------------------

  task automatic sender_pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_chan.valid    = 1'b0;
      // noise on the idle bus must not be taken
      in_chan.chroma_u = 8'($urandom_range(0, 255));
      in_chan.chroma_v = 8'($urandom_range(0, 255));
    end
  endtask

  // Offers one request and returns at the edge it is taken. valid is left
  // high so a following request goes out back to back.
  task automatic offer_site(input logic [7:0] tl, tr, bl, br, u, v);
    if (sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
      sender_pause($urandom_range(1, 14));
    end
    @(negedge clk);
    in_chan.valid             = 1'b1;
    in_chan.luma_top_left     = tl;
    in_chan.luma_top_right    = tr;
    in_chan.luma_bottom_left  = bl;
    in_chan.luma_bottom_right = br;
    in_chan.chroma_u          = u;
    in_chan.chroma_v          = v;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Half the requests are aimed at the edges of one colour's ranges, the rest
  // are free samples
  task automatic random_site();
    range_t     r;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
    logic [7:0] l0;
    logic [7:0] l1;
    logic [7:0] l2;
    logic [7:0] l3;
    if ($urandom_range(0, 1) == 1) begin
      r = range_plan[CFG_IDX_W'($urandom_range(0, REG_COUNT - 1))];
      y = near_edge(r.y_lo, r.y_hi);
      u = near_edge(r.u_lo, r.u_hi);
      v = near_edge(r.v_lo, r.v_hi);
      spread_luma(y, l0, l1, l2, l3);
    end else begin
      u  = 8'($urandom_range(0, 255));
      v  = 8'($urandom_range(0, 255));
      l0 = 8'($urandom_range(0, 255));
      l1 = 8'($urandom_range(0, 255));
      l2 = 8'($urandom_range(0, 255));
      l3 = 8'($urandom_range(0, 255));
    end
    offer_site(l0, l1, l2, l3, u, v);
  endtask

  // Drop valid and wait for every outstanding mask; the core keeps no request
  // without a result, so it is idle once the last one has come.
  task automatic settle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (masks_outstanding != 0) @(negedge clk);
  endtask

  // Writes all eight colour registers from range_plan, one per cycle
  task automatic program_ranges();
    int k;
    for (k = 0; k < REG_COUNT; k++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = k[CFG_IDX_W-1:0];
      cfg_wdata = range_plan[k];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // A run of random requests; with squeeze the receiver is told to hold off
  // early on while requests keep coming, so the pipe fills and stalls.
  task automatic random_phase(input int count, input bit squeeze);
    int n;
    for (n = 0; n < count; n++) begin
      random_site();
      if (squeeze && n == 20) begin
        sink_hold_req = 1'b1;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, a long hold-off on request, or steady ready
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req  = 1'b0;
        out_chan.ready = 1'b0;
        repeat (80) @(negedge clk);
      end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int k;
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = '0;
    cfg_wdata                 = '0;
    in_chan.valid             = 1'b0;
    in_chan.luma_top_left     = '0;
    in_chan.luma_top_right    = '0;
    in_chan.luma_bottom_left  = '0;
    in_chan.luma_bottom_right = '0;
    in_chan.chroma_u          = '0;
    in_chan.chroma_v          = '0;
    sender_gap_odds           = 0;
    sink_stall_odds           = 0;
    sink_hold_req             = 1'b0;
    for (k = 0; k < REG_COUNT; k++) begin
      range_plan[k] = '0;
    end

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Straight after reset every colour is empty: masks must read zero
    offer_site(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    offer_site(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    offer_site(8'd128, 8'd127, 8'd129, 8'd128, 8'd128, 8'd128);
    settle();

    // Hand-picked ranges: wrapping, single-value, empty and near-full
    range_plan[0] = pack_range(8'd1,   8'd0,   8'd0,   8'd255, 8'd0,   8'd255);
    range_plan[1] = pack_range(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0);
    range_plan[2] = pack_range(8'd0,   8'd1,   8'd0,   8'd1,   8'd0,   8'd1);
    range_plan[3] = pack_range(8'd128, 8'd128, 8'd0,   8'd255, 8'd0,   8'd255);
    range_plan[4] = pack_range(8'd200, 8'd50,  8'd16,  8'd240, 8'd16,  8'd240);
    range_plan[5] = pack_range(8'd16,  8'd236, 8'd128, 8'd129, 8'd100, 8'd200);
    range_plan[6] = pack_range(8'd64,  8'd192, 8'd200, 8'd100, 8'd250, 8'd5);
    range_plan[7] = pack_range(8'd0,   8'd255, 8'd1,   8'd0,   8'd254, 8'd255);
    program_ranges();

    // extremes of every field
    offer_site(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    offer_site(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    // luma average truncates: sums of 1019, 3, 3, 4 and 1020
    offer_site(8'd255, 8'd255, 8'd255, 8'd254, 8'd128, 8'd254);
    offer_site(8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0);
    offer_site(8'd3,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1);
    offer_site(8'd2,   8'd1,   8'd1,   8'd0,   8'd128, 8'd150);
    offer_site(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd150);
    // both edges of the wrapping luma range of colour 4
    offer_site(8'd200, 8'd200, 8'd200, 8'd199, 8'd128, 8'd150);
    offer_site(8'd200, 8'd200, 8'd200, 8'd200, 8'd16,  8'd239);
    offer_site(8'd50,  8'd50,  8'd50,  8'd49,  8'd239, 8'd16);
    offer_site(8'd50,  8'd50,  8'd50,  8'd50,  8'd240, 8'd16);
    // ordinary range edges of colour 5, single U value
    offer_site(8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd100);
    offer_site(8'd236, 8'd236, 8'd236, 8'd235, 8'd128, 8'd199);
    offer_site(8'd236, 8'd236, 8'd236, 8'd236, 8'd128, 8'd200);
    // chroma wrapping on colour 6
    offer_site(8'd64,  8'd64,  8'd64,  8'd64,  8'd99,  8'd4);
    offer_site(8'd191, 8'd192, 8'd192, 8'd192, 8'd100, 8'd5);
    offer_site(8'd192, 8'd192, 8'd192, 8'd192, 8'd200, 8'd250);
    // middle of the empty luma range of colour 3
    offer_site(8'd128, 8'd128, 8'd128, 8'd128, 8'd127, 8'd249);
    offer_site(8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd254);
    // alternating bit patterns
    offer_site(8'd170, 8'd85,  8'd170, 8'd85,  8'd85,  8'd170);
    offer_site(8'd85,  8'd170, 8'd85,  8'd170, 8'd170, 8'd85);
    settle();

    // Random part with idling on both sides
    sender_gap_odds = 6;
    sink_stall_odds = 6;

    // all bytes 0xff: every range empty
    for (k = 0; k < REG_COUNT; k++) begin
      range_plan[k] = '1;
    end
    program_ranges();
    random_phase(40, 1'b0);

    // all bytes zero: empty again, as after reset
    for (k = 0; k < REG_COUNT; k++) begin
      range_plan[k] = '0;
    end
    program_ranges();
    random_phase(40, 1'b0);

    for (p = 0; p < 5; p++) begin
      for (k = 0; k < REG_COUNT; k++) begin
        range_plan[k] = random_range();
      end
      case (p)
        0:       begin sender_gap_odds = 4;  sink_stall_odds = 5; end
        1:       begin sender_gap_odds = 0;  sink_stall_odds = 8; end
        2:       begin sender_gap_odds = 10; sink_stall_odds = 0; end
        3:       begin sender_gap_odds = 0;  sink_stall_odds = 4; end
        default: begin sender_gap_odds = 3;  sink_stall_odds = 3; end
      endcase
      program_ranges();
      random_phase(300, (p == 1) || (p == 3));
    end

    // Closing stretch at full rate, no idling on either side
    sender_gap_odds = 0;
    sink_stall_odds = 0;
    for (k = 0; k < REG_COUNT; k++) begin
      range_plan[k] = random_range();
    end
    program_ranges();
    random_phase(280, 1'b0);

    // idle past the pipe depth to catch stray results
    repeat (12) @(negedge clk);
    if (mismatch_count == 0 && masks_outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ycrc_pkg.sv
rtl/core/ycrc_if.sv
rtl/core/ycrc_cfg_regs.sv
rtl/core/ycrc_luma_avg.sv
rtl/core/ycrc_range_match.sv
rtl/core/yuv_color_range_classifier_core.sv
dv/ycrc_mask_checker.sv
dv/tb_yuv_color_range_classifier_core.sv
